>>> rtl/lru2_pkg.sv
// Package: request codes, register map and controller states for the LRU-2 victim selector.
`timescale 1ns / 1ps
`default_nettype none

package lru2_pkg;

    typedef enum logic [1:0] {
        REQ_ACCESS = 2'd0,
        REQ_RESET  = 2'd1,
        REQ_SELECT = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_SCAN
    } state_t;

    localparam int          TIME_W        = 64;
    localparam int          FIU_W         = 5;
    localparam int          MASK_W        = 16;
    localparam int          VIDX_W        = 4;
    localparam int          PADDR_W       = 3;
    localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;
    localparam logic        REG_FIU_SEL   = 1'b0;

endpackage

`default_nettype wire

>>> rtl/lru2_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lru2_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/lru2_victim_select.sv
// Top level: LRU-2 victim selector with frame history held in one synchronous RAM.
// Access: RAM read of the frame entry, then its read-modify-write in ST_ACC.
// History reset: clears the frame's valid bit.
// Select: scans the first min(frames_in_use, NUM_FRAMES) frames; no new item is taken until the result is registered.
// Results leave through an output register; a new item is taken while one waits there.
// Reset (rst_n low, async): all frames read as never accessed, clock zero, frames_in_use 16.
`timescale 1ns / 1ps
`default_nettype none

module lru2_victim_select
    import lru2_pkg::*;
#(
    parameter int NUM_FRAMES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [23:0]        s_tdata,   // frame_index[3:0], pinned_mask[19:4], zero
    input  wire logic [1:0]         s_tuser,   // req_type[1:0]
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,   // victim_index[3:0], zero
    output logic                    m_tuser,   // victim_found
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int IDX_W = $clog2(NUM_FRAMES);
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int CMP_W = (CNT_W > FIU_W) ? CNT_W : FIU_W;
    localparam int ENT_W = 2 * TIME_W;

    state_t state_reg, state_next;

    logic [FIU_W-1:0]      fiu_reg;
    logic [TIME_W-1:0]     clock_reg;
    logic [NUM_FRAMES-1:0] vld_reg;
    logic [IDX_W-1:0]      acc_idx_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      limit_reg;
    logic                  eval_vld_reg;
    logic [IDX_W-1:0]      eval_idx_reg;
    logic                  have_single_reg;
    logic [IDX_W-1:0]      single_idx_reg;
    logic [TIME_W-1:0]     single_time_reg;
    logic                  have_double_reg;
    logic [IDX_W-1:0]      double_idx_reg;
    logic [TIME_W-1:0]     double_time_reg;
    logic                  m_tvalid_reg;
    logic                  m_found_reg;
    logic [VIDX_W-1:0]     m_idx_reg;

    logic                  in_acc;
    logic                  cfg_wr;
    req_t                  req;
    logic [CMP_W-1:0]      fidx_ext;
    logic                  in_range;
    logic [CMP_W-1:0]      fiu_ext;
    logic [CNT_W-1:0]      limit_calc;
    logic                  issue;
    logic                  scan_done;
    logic                  out_free;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENT_W-1:0]      ram_wdata;
    logic [ENT_W-1:0]      ram_rdata;
    logic [TIME_W-1:0]     rd_newest;
    logic [TIME_W-1:0]     rd_older;
    logic [NUM_FRAMES-1:0] pin_vec;
    logic                  eval_pinned;
    logic                  take_single;
    logic                  take_double;
    logic                  res_found;
    logic [IDX_W-1:0]      res_idx;
    logic [CMP_W-1:0]      res_idx_ext;

    assign req       = req_t'(s_tuser);
    assign fidx_ext  = CMP_W'(s_tdata[3:0]);
    assign in_range  = fidx_ext < CMP_W'(NUM_FRAMES);
    assign fiu_ext   = CMP_W'(fiu_reg);
    assign limit_calc = (fiu_ext > CMP_W'(NUM_FRAMES)) ? CNT_W'(NUM_FRAMES) : CNT_W'(fiu_ext);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == REG_FIU_SEL);
    assign issue     = (state_reg == ST_SCAN) && (cnt_reg < limit_reg);
    assign scan_done = (state_reg == ST_SCAN) && (cnt_reg == limit_reg) && !eval_vld_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    genvar g;
    generate
        for (g = 0; g < NUM_FRAMES; g++)
        begin : g_pin
            if (g < MASK_W)
            begin : g_in
                assign pin_vec[g] = mask_reg[g];
            end
            else
            begin : g_out
                assign pin_vec[g] = 1'b0;
            end
        end
    endgenerate

    assign rd_newest   = vld_reg[eval_idx_reg] ? ram_rdata[ENT_W-1:TIME_W] : '0;
    assign rd_older    = vld_reg[eval_idx_reg] ? ram_rdata[TIME_W-1:0] : '0;
    assign eval_pinned = pin_vec[eval_idx_reg];
    assign take_single = eval_vld_reg && !eval_pinned && (rd_older == '0)
                         && (!have_single_reg || (rd_newest < single_time_reg));
    assign take_double = eval_vld_reg && !eval_pinned && (rd_older != '0)
                         && (!have_double_reg || (rd_older < double_time_reg));

    assign res_found   = have_single_reg || have_double_reg;
    assign res_idx     = have_single_reg ? single_idx_reg :
                         (have_double_reg ? double_idx_reg : '0);
    assign res_idx_ext = CMP_W'(res_idx);

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        ram_raddr  = fidx_ext[IDX_W-1:0];
        ram_we     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (req == REQ_ACCESS && in_range)
                    begin
                        state_next = ST_ACC;
                    end
                    else if (req == REQ_SELECT)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_ACC:
            begin
                ram_we     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                ram_raddr = cnt_reg[IDX_W-1:0];
                if (scan_done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ram_wdata = {clock_reg + TIME_W'(1),
                        vld_reg[acc_idx_reg] ? ram_rdata[ENT_W-1:TIME_W] : TIME_W'(0)};

    lru2_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (acc_idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg         <= FIU_RESET;
            clock_reg       <= '0;
            vld_reg         <= '0;
            eval_vld_reg    <= 1'b0;
            have_single_reg <= 1'b0;
            have_double_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            cnt_reg         <= '0;
            limit_reg       <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                fiu_reg <= pwdata[FIU_W-1:0];
            end
            if (in_acc && req == REQ_RESET && in_range)
            begin
                vld_reg[fidx_ext[IDX_W-1:0]] <= 1'b0;
            end
            if (ram_we)
            begin
                vld_reg[acc_idx_reg] <= 1'b1;
                clock_reg            <= clock_reg + TIME_W'(1);
            end
            if (in_acc && req == REQ_SELECT)
            begin
                cnt_reg         <= '0;
                limit_reg       <= limit_calc;
                have_single_reg <= 1'b0;
                have_double_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (take_single)
                begin
                    have_single_reg <= 1'b1;
                end
                if (take_double)
                begin
                    have_double_reg <= 1'b1;
                end
            end
            eval_vld_reg <= issue;
            if (scan_done && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            acc_idx_reg <= fidx_ext[IDX_W-1:0];
            mask_reg    <= s_tdata[19:4];
        end
        eval_idx_reg <= cnt_reg[IDX_W-1:0];
        if (take_single)
        begin
            single_idx_reg  <= eval_idx_reg;
            single_time_reg <= rd_newest;
        end
        if (take_double)
        begin
            double_idx_reg  <= eval_idx_reg;
            double_time_reg <= rd_older;
        end
        if (scan_done && out_free)
        begin
            m_found_reg <= res_found;
            m_idx_reg   <= res_idx_ext[VIDX_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {4'b0000, m_idx_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_FIU_SEL) ? 32'(fiu_reg) : 32'h0;

endmodule

`default_nettype wire

>>> rtl/lru2_checker.sv
// Checker: port-level properties of the LRU-2 victim selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lru2_checker
    import lru2_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [1:0] s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[3:0] == 4'h0)
        else $error("not-found result carries a nonzero index");

    a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == REQ_SELECT |=> !s_tready)
        else $error("item accepted during a victim scan");

    a_reset_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == REQ_RESET |=> s_tready)
        else $error("history reset did not complete in one cycle");

endmodule

bind lru2_victim_select lru2_checker u_lru2_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/tb_lru2_victim_select.sv
// Testbench for the LRU-2 victim selector: directed table, random traffic, scoreboard check.
`timescale 1ns / 1ps

module tb_lru2_victim_select;
    import lru2_pkg::*;

    localparam int FRAMES       = 16;
    localparam int ITEMS_TOTAL  = 1550;
    localparam int PHASES       = 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 300;
    localparam logic [PADDR_W-1:0] FIU_ADDR = {REG_FIU_SEL, 2'b00};

    typedef struct packed {
        logic              found;
        logic [VIDX_W-1:0] index;
    } victim_t;

    typedef struct packed {
        req_t              req;
        logic [3:0]        frame;
        logic [MASK_W-1:0] mask;
        bit                typed;
        victim_t           want;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [23:0]        s_tdata;   // frame_index[3:0], pinned_mask[19:4], zero
    logic [1:0]         s_tuser;   // req_type[1:0]
    logic               m_tvalid;
    logic               m_tready;
    logic [7:0]         m_tdata;   // victim_index[3:0], zero
    logic               m_tuser;   // victim_found
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    lru2_victim_select #(
        .NUM_FRAMES(FRAMES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic [TIME_W-1:0] stamp_newest [FRAMES];
    logic [TIME_W-1:0] stamp_older  [FRAMES];
    logic [TIME_W-1:0] stamp_clock;
    logic [FIU_W-1:0]  scan_count;

    victim_t pending_victims [$];
    int      error_count;
    int      items_sent;
    int      victims_checked;
    int      settings_used;
    bit      quiet;
    bit      hold_request;

    stim_row_t dir_rows [0:20] = '{
        '{REQ_SELECT, 4'd0,  16'h0000, 1'b1, '{1'b1, 4'd0}},
        '{REQ_SELECT, 4'd0,  16'hFFFF, 1'b1, '{1'b0, 4'd0}},
        '{REQ_SELECT, 4'd0,  16'h7FFF, 1'b1, '{1'b1, 4'd15}},
        '{REQ_ACCESS, 4'd0,  16'h0000, 1'b0, '{1'b0, 4'd0}},
        '{REQ_ACCESS, 4'd0,  16'h0000, 1'b0, '{1'b0, 4'd0}},
        '{REQ_SELECT, 4'd0,  16'h0000, 1'b0, '{1'b0, 4'd0}},
        '{REQ_ACCESS, 4'd15, 16'hFFFF, 1'b0, '{1'b0, 4'd0}},
        '{REQ_SELECT, 4'd0,  16'hFFFE, 1'b0, '{1'b0, 4'd0}},
        '{REQ_SELECT, 4'd0,  16'h0001, 1'b0, '{1'b0, 4'd0}},
        '{REQ_RESET,  4'd0,  16'h0000, 1'b0, '{1'b0, 4'd0}},
        '{REQ_SELECT, 4'd0,  16'hFFFE, 1'b0, '{1'b0, 4'd0}},
        '{REQ_NONE,   4'd15, 16'hFFFF, 1'b0, '{1'b0, 4'd0}},
        '{REQ_SELECT, 4'd15, 16'h0000, 1'b0, '{1'b0, 4'd0}},
        '{REQ_RESET,  4'd15, 16'hFFFF, 1'b0, '{1'b0, 4'd0}},
        '{REQ_ACCESS, 4'd15, 16'h0000, 1'b0, '{1'b0, 4'd0}},
        '{REQ_ACCESS, 4'd15, 16'h0000, 1'b0, '{1'b0, 4'd0}},
        '{REQ_SELECT, 4'd0,  16'h7FFF, 1'b0, '{1'b0, 4'd0}},
        '{REQ_ACCESS, 4'd3,  16'h0000, 1'b0, '{1'b0, 4'd0}},
        '{REQ_ACCESS, 4'd3,  16'h0000, 1'b0, '{1'b0, 4'd0}},
        '{REQ_SELECT, 4'd0,  16'h7FF7, 1'b0, '{1'b0, 4'd0}},
        '{REQ_SELECT, 4'd0,  16'hFFFF, 1'b1, '{1'b0, 4'd0}}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic history_clear();
        for (int i = 0; i < FRAMES; i++)
        begin
            stamp_newest[i] = '0;
            stamp_older[i]  = '0;
        end
        stamp_clock = '0;
        scan_count  = FIU_RESET;
    endtask

    task automatic history_apply(input req_t req, input logic [3:0] frame,
                                 input logic [MASK_W-1:0] mask,
                                 output bit emits, output victim_t v);
        int                limit;
        bit                have_single;
        bit                have_double;
        bit                pinned;
        int                single_idx;
        int                double_idx;
        logic [TIME_W-1:0] single_t;
        logic [TIME_W-1:0] double_t;
        emits       = 1'b0;
        v           = '0;
        have_single = 1'b0;
        have_double = 1'b0;
        single_idx  = 0;
        double_idx  = 0;
        single_t    = '0;
        double_t    = '0;
        case (req)
            REQ_ACCESS:
            begin
                if (int'(frame) < FRAMES)
                begin
                    stamp_clock         = stamp_clock + 1'b1;
                    stamp_older[frame]  = stamp_newest[frame];
                    stamp_newest[frame] = stamp_clock;
                end
            end
            REQ_RESET:
            begin
                if (int'(frame) < FRAMES)
                begin
                    stamp_newest[frame] = '0;
                    stamp_older[frame]  = '0;
                end
            end
            REQ_SELECT:
            begin
                limit = (int'(scan_count) > FRAMES) ? FRAMES : int'(scan_count);
                for (int i = 0; i < limit; i++)
                begin
                    pinned = (i < MASK_W) && mask[i];
                    if (!pinned)
                    begin
                        if (stamp_older[i] == '0)
                        begin
                            if (!have_single || stamp_newest[i] < single_t)
                            begin
                                have_single = 1'b1;
                                single_idx  = i;
                                single_t    = stamp_newest[i];
                            end
                        end
                        else if (!have_double || stamp_older[i] < double_t)
                        begin
                            have_double = 1'b1;
                            double_idx  = i;
                            double_t    = stamp_older[i];
                        end
                    end
                end
                emits = 1'b1;
                if (have_single)
                begin
                    v.found = 1'b1;
                    v.index = single_idx[VIDX_W-1:0];
                end
                else if (have_double)
                begin
                    v.found = 1'b1;
                    v.index = double_idx[VIDX_W-1:0];
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input req_t req, input logic [3:0] frame,
                             input logic [MASK_W-1:0] mask,
                             input bit typed, input victim_t want);
        bit      emits;
        victim_t v;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, mask, frame};
        s_tuser  <= req;
        do
            @(posedge clk);
        while (!s_tready);
        history_apply(req, frame, mask, emits, v);
        if (emits)
            pending_victims.push_back(typed ? want : v);
        if (req != REQ_NONE)
            items_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= FIU_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        if (wr)
            scan_count = wdata[FIU_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_scan_count(input int unsigned value);
        logic [31:0] rd;
        while (pending_victims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        apb_xfer(1'b1, value, rd);
        @(posedge clk);
        apb_xfer(1'b0, '0, rd);
        if (rd[FIU_W-1:0] !== value[FIU_W-1:0])
        begin
            $error("frames_in_use readback expected %0d actual %0d",
                   value[FIU_W-1:0], rd[FIU_W-1:0]);
            error_count++;
        end
        settings_used++;
    endtask

    function automatic logic [MASK_W-1:0] pick_mask();
        logic [MASK_W-1:0] one;
        one = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return ~one;
            3:       return one;
            4, 5:    return MASK_W'($urandom & $urandom & $urandom);
            default: return MASK_W'($urandom);
        endcase
    endfunction

    task automatic send_random();
        int          pick;
        int          span;
        req_t        req;
        logic [3:0]  frame;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            req = REQ_ACCESS;
        else if (pick < 57)
            req = REQ_RESET;
        else if (pick < 95)
            req = REQ_SELECT;
        else
            req = REQ_NONE;
        span = (int'(scan_count) > FRAMES) ? FRAMES : int'(scan_count);
        if (span != 0 && $urandom_range(0, 3) != 0)
            frame = 4'($urandom_range(0, span - 1));
        else
            frame = 4'($urandom_range(0, 15));
        send_item(req, frame, pick_mask(), 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        victim_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_victims.size() == 0)
            begin
                $error("unexpected result: victim_found %0d victim_index %0d",
                       m_tuser, m_tdata[VIDX_W-1:0]);
                error_count++;
            end
            else
            begin
                e = pending_victims.pop_front();
                if (m_tuser !== e.found)
                begin
                    $error("victim_found expected %0d actual %0d", e.found, m_tuser);
                    error_count++;
                end
                if (m_tdata[VIDX_W-1:0] !== e.index)
                begin
                    $error("victim_index expected %0d actual %0d",
                           e.index, m_tdata[VIDX_W-1:0]);
                    error_count++;
                end
                victims_checked++;
            end
        end
    end

    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                m_tready <= 1'b1;
                repeat (quiet ? 1 : $urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb_lru2_victim_select: errors");
        $finish;
    end

    initial
    begin
        int unsigned scan_plan [PHASES];
        int          per_phase;
        int          target;
        logic [31:0] rd;
        rst_n           = 1'b0;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tuser         <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        error_count     = 0;
        items_sent      = 0;
        victims_checked = 0;
        settings_used   = 0;
        quiet           = 1'b0;
        hold_request    = 1'b0;
        history_clear();
        scan_plan = '{16, 1, 31, 0, 17, 2, $urandom_range(0, 31), 16};
        per_phase = ITEMS_TOTAL / PHASES;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_xfer(1'b0, '0, rd);
        if (rd[FIU_W-1:0] !== FIU_RESET)
        begin
            $error("frames_in_use readback expected %0d actual %0d", FIU_RESET, rd[FIU_W-1:0]);
            error_count++;
        end

        for (int r = 0; r <= 20; r++)
            send_item(dir_rows[r].req, dir_rows[r].frame, dir_rows[r].mask,
                      dir_rows[r].typed, dir_rows[r].want);
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            set_scan_count(scan_plan[p]);
            quiet  = (p == PHASES - 1);
            target = items_sent + per_phase;
            while (items_sent < target)
            begin
                if (p == 0 && items_sent == target - per_phase + 20)
                    hold_request = 1'b1;
                send_random();
            end
            s_tvalid <= 1'b0;
        end

        while (pending_victims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d items over %0d scan-count settings", items_sent, settings_used);
        $display("%0d victim results compared, access clock reached %0d",
                 victims_checked, stamp_clock);
        if (error_count == 0)
            $display("tb_lru2_victim_select: clean");
        else
            $display("tb_lru2_victim_select: errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/lru2_pkg.sv
rtl/lru2_ram.sv
rtl/lru2_victim_select.sv
rtl/lru2_checker.sv
tb/tb_lru2_victim_select.sv
